>>> hdl/ipre_pkg.sv
// ----------------------------------------------------------------------------
// ipre_pkg
// Shared codes, controller/datapath command and status types, and the
// header and trailer text of the patch stream.
// ----------------------------------------------------------------------------
package ipre_pkg;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_COMPARE = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // shortest record that goes out in run-length form
  localparam int unsigned RUN_MIN = 4;

  typedef enum logic [2:0] {
    SEL_PATCH,
    SEL_EOF,
    SEL_OFFSET,
    SEL_ZERO,
    SEL_COUNT,
    SEL_FIRST,
    SEL_RECORD
  } byte_sel_t;

  typedef struct packed {
    logic      clear;
    logic      advance;
    logic      append_live;
    logic      append_held;
    logic      hold_item;
    logic      flush_done;
    logic      emit;
    byte_sel_t sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic changed;
    logic count_zero;
    logic count_full;
    logic rle;
    logic lit_last;
    logic out_space;
  } dp_status_t;

  function automatic logic [7:0] magic_byte(input logic is_eof, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (is_eof) begin
      unique case (idx)
        3'd0:    b = 8'h45;  // E
        3'd1:    b = 8'h4F;  // O
        3'd2:    b = 8'h46;  // F
        default: b = 8'h00;
      endcase
    end else begin
      unique case (idx)
        3'd0:    b = 8'h50;  // P
        3'd1:    b = 8'h41;  // A
        3'd2:    b = 8'h54;  // T
        3'd3:    b = 8'h43;  // C
        3'd4:    b = 8'h48;  // H
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

>>> hdl/ipre_ram.sv
// ----------------------------------------------------------------------------
// ipre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/ipre_dp.sv
// ----------------------------------------------------------------------------
// ipre_dp
// Datapath: record buffer, record count, offset, run flag, image position
// and the output word register.
// ----------------------------------------------------------------------------
module ipre_dp
  import ipre_pkg::*;
#(
  parameter int MAX_RECORD = 48,
  parameter int CNT_W      = $clog2(MAX_RECORD + 1),
  parameter int AW         = $clog2(MAX_RECORD)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       old_byte,
  input  logic             old_present,
  input  logic [7:0]       new_byte,
  input  dp_cmd_t          ctl,
  input  logic [CNT_W-1:0] step,
  input  logic [AW-1:0]    rd_addr,
  output dp_status_t       st,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  logic [CNT_W-1:0] count;
  logic [23:0]      offset;
  logic             run;
  logic [23:0]      position;
  logic [7:0]       first;
  logic [7:0]       item_byte;
  logic [7:0]       append_b;
  logic             append;
  logic [7:0]       rd_data;
  logic [7:0]       emit_byte;

  assign append   = ctl.append_live | ctl.append_held;
  assign append_b = ctl.append_held ? item_byte : new_byte;

  ipre_ram #(
    .WIDTH(8),
    .DEPTH(MAX_RECORD)
  ) u_ram (
    .clk    (clk),
    .wr_en  (append),
    .wr_addr(count[AW-1:0]),
    .wr_data(append_b),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    st.changed    = !old_present || (old_byte != new_byte);
    st.count_zero = (count == '0);
    st.count_full = (count >= CNT_W'(MAX_RECORD));
    st.rle        = run && (count >= CNT_W'(RUN_MIN));
    st.lit_last   = ((step + CNT_W'(1)) == count);
    st.out_space  = !out_valid || !out_stall;
  end

  always_comb begin
    emit_byte = 8'h00;
    unique case (ctl.sel)
      SEL_PATCH:  emit_byte = magic_byte(1'b0, step[2:0]);
      SEL_EOF:    emit_byte = magic_byte(1'b1, step[2:0]);
      SEL_OFFSET: begin
        unique case (step[1:0])
          2'd0:    emit_byte = offset[23:16];
          2'd1:    emit_byte = offset[15:8];
          default: emit_byte = offset[7:0];
        endcase
      end
      SEL_ZERO:   emit_byte = 8'h00;
      SEL_COUNT:  emit_byte = 8'(count);
      SEL_FIRST:  emit_byte = first;
      SEL_RECORD: emit_byte = rd_data;
      default:    emit_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      offset    <= '0;
      run       <= 1'b0;
      position  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        count    <= '0;
        offset   <= '0;
        run      <= 1'b0;
        position <= '0;
      end
      if (ctl.flush_done) begin
        count  <= '0;
        offset <= '0;
        run    <= 1'b0;
      end
      if (append) begin
        if (count == '0) begin
          offset <= position;
          run    <= 1'b1;
        end else if (append_b != first) begin
          run <= 1'b0;
        end
        count <= count + CNT_W'(1);
      end
      if (ctl.advance) begin
        position <= position + 24'd1;
      end
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hold_item) begin
      item_byte <= new_byte;
    end
    if (append && (count == '0)) begin
      first <= append_b;
    end
    if (ctl.emit) begin
      out_byte <= emit_byte;
      out_last <= ctl.last;
    end
  end

endmodule

>>> hdl/ipre_ctrl.sv
// ----------------------------------------------------------------------------
// ipre_ctrl
// Controller: takes input words, sequences header, record and trailer
// bytes into the datapath's output register.
// ----------------------------------------------------------------------------
module ipre_ctrl
  import ipre_pkg::*;
#(
  parameter int MAX_RECORD = 48,
  parameter int CNT_W      = $clog2(MAX_RECORD + 1),
  parameter int AW         = $clog2(MAX_RECORD)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       cmd,
  input  dp_status_t       st,
  output dp_cmd_t          ctl,
  output logic [CNT_W-1:0] step,
  output logic [AW-1:0]    rd_addr
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAGIC  = 3'd1;
  localparam logic [2:0] S_OFF    = 3'd2;
  localparam logic [2:0] S_HDR    = 3'd3;
  localparam logic [2:0] S_LIT    = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;

  localparam logic [1:0] JOB_START  = 2'd0;
  localparam logic [1:0] JOB_FLUSH  = 2'd1;
  localparam logic [1:0] JOB_REFILL = 2'd2;
  localparam logic [1:0] JOB_FINISH = 2'd3;

  logic [2:0]       state, state_next;
  logic [1:0]       job, job_next;
  logic [CNT_W-1:0] step_next;
  logic             flush_end;

  assign in_stall = (state != S_IDLE);
  // read one step ahead so record data lines up with the step
  assign rd_addr  = step_next[AW-1:0];

  always_comb begin
    state_next = state;
    job_next   = job;
    step_next  = step;
    ctl        = '0;
    ctl.sel    = SEL_ZERO;
    flush_end  = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.hold_item = 1'b1;
          step_next     = '0;
          unique case (cmd)
            CMD_START: begin
              ctl.clear  = 1'b1;
              job_next   = JOB_START;
              state_next = S_MAGIC;
            end
            CMD_COMPARE: begin
              if (!st.changed) begin
                if (st.count_zero) begin
                  ctl.advance = 1'b1;
                end else begin
                  job_next   = JOB_FLUSH;
                  state_next = S_OFF;
                end
              end else if (!st.count_full) begin
                ctl.append_live = 1'b1;
                ctl.advance     = 1'b1;
              end else begin
                job_next   = JOB_REFILL;
                state_next = S_OFF;
              end
            end
            CMD_FINISH: begin
              job_next   = JOB_FINISH;
              state_next = st.count_zero ? S_MAGIC : S_OFF;
            end
            default: ;
          endcase
        end
      end

      S_MAGIC: begin
        ctl.sel = (job == JOB_FINISH) ? SEL_EOF : SEL_PATCH;
        if (st.out_space) begin
          ctl.emit = 1'b1;
          ctl.last = (job == JOB_FINISH) ? (step == CNT_W'(2)) : (step == CNT_W'(4));
          if (ctl.last) begin
            state_next = S_IDLE;
          end else begin
            step_next = step + CNT_W'(1);
          end
        end
      end

      S_OFF: begin
        ctl.sel = SEL_OFFSET;
        if (st.out_space) begin
          ctl.emit = 1'b1;
          if (step == CNT_W'(2)) begin
            step_next  = '0;
            state_next = S_HDR;
          end else begin
            step_next = step + CNT_W'(1);
          end
        end
      end

      S_HDR: begin
        if (st.rle) begin
          // zero size, zero high count, count, value
          if (step == CNT_W'(4)) begin
            ctl.sel = SEL_FIRST;
          end else if (step == CNT_W'(3)) begin
            ctl.sel = SEL_COUNT;
          end else begin
            ctl.sel = SEL_ZERO;
          end
        end else begin
          ctl.sel = (step == CNT_W'(1)) ? SEL_COUNT : SEL_ZERO;
        end
        if (st.out_space) begin
          ctl.emit = 1'b1;
          if (st.rle && (step == CNT_W'(4))) begin
            flush_end = 1'b1;
          end else if (!st.rle && (step == CNT_W'(1))) begin
            step_next  = '0;
            state_next = S_LIT;
          end else begin
            step_next = step + CNT_W'(1);
          end
        end
      end

      S_LIT: begin
        ctl.sel = SEL_RECORD;
        if (st.out_space) begin
          ctl.emit = 1'b1;
          if (st.lit_last) begin
            flush_end = 1'b1;
          end else begin
            step_next = step + CNT_W'(1);
          end
        end
      end

      S_APPEND: begin
        ctl.append_held = 1'b1;
        ctl.advance     = 1'b1;
        state_next      = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase

    // record is out: close it and move on to what the word still needs
    if (flush_end) begin
      ctl.flush_done = 1'b1;
      // only finish has more bytes to send after the record
      ctl.last       = (job == JOB_FLUSH) || (job == JOB_REFILL);
      step_next      = '0;
      unique case (job)
        JOB_FLUSH: begin
          ctl.advance = 1'b1;
          state_next  = S_IDLE;
        end
        JOB_REFILL: state_next = S_APPEND;
        default:    state_next = S_MAGIC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= JOB_START;
      step  <= '0;
    end else begin
      state <= state_next;
      job   <= job_next;
      step  <= step_next;
    end
  end

endmodule

>>> hdl/ips_patch_record_encoder_unit.sv
// A word that emits bytes is taken in S_IDLE and its first byte loaded from the state
//   after, once out_space is high. A compare word that appends or has nothing to flush
//   leaves in_stall low; one that emits n bytes (3 to 56) keeps it high through them,
//   through out_stall and S_APPEND after a full record, via the single output register.
// Reset (rst, synchronous): clears record count, offset, run flag, position, controller
//   state and output valid; the record buffer RAM is not cleared.
// ----------------------------------------------------------------------------
// ips_patch_record_encoder_unit
// Compares old/new image bytes and streams an IPS patch with run-length
// records; controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
module ips_patch_record_encoder_unit
  import ipre_pkg::*;
#(
  parameter int MAX_RECORD = 48
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] old_byte,
  input  logic       old_present,
  input  logic [7:0] new_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam int CNT_W = $clog2(MAX_RECORD + 1);
  localparam int AW    = $clog2(MAX_RECORD);

  dp_cmd_t          ctl;
  dp_status_t       st;
  logic [CNT_W-1:0] step;
  logic [AW-1:0]    rd_addr;

  ipre_ctrl #(
    .MAX_RECORD(MAX_RECORD),
    .CNT_W     (CNT_W),
    .AW        (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .st      (st),
    .ctl     (ctl),
    .step    (step),
    .rd_addr (rd_addr)
  );

  ipre_dp #(
    .MAX_RECORD(MAX_RECORD),
    .CNT_W     (CNT_W),
    .AW        (AW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .old_byte   (old_byte),
    .old_present(old_present),
    .new_byte   (new_byte),
    .ctl        (ctl),
    .step       (step),
    .rd_addr    (rd_addr),
    .st         (st),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

>>> hdl/ipre_checker.sv
// ----------------------------------------------------------------------------
// ipre_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ipre_checker
  import ipre_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] cmd,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  // start and finish always produce bytes, so the input side goes busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == CMD_START || cmd == CMD_FINISH) |=> in_stall)
    else $error("start or finish word did not begin emitting");

  // the unused command is dropped without holding the input
  a_unused_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == CMD_UNUSED |=> !in_stall)
    else $error("unused command stalled the input");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or input busy after reset");

endmodule

bind ips_patch_record_encoder_unit ipre_checker u_ipre_checker (.*);
